/* rtl/keyed_group_sum_table_assert.svh */
// ----------------------------------------------------------------------------
// keyed_group_sum_table_assert.svh
// Assertion macros for the group-by sum table, clocked on clk, held off in rst.
// ----------------------------------------------------------------------------
`ifndef KEYED_GROUP_SUM_TABLE_ASSERT_SVH
`define KEYED_GROUP_SUM_TABLE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define KGST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define KGST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kgst_pkg.sv */
// ----------------------------------------------------------------------------
// kgst_pkg
// Shared types, sizes, codes and the name clean-up function of the sum table.
// ----------------------------------------------------------------------------
package kgst_pkg;

  // Table geometry
  localparam int ENTRIES  = 256;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int IN_IDX_W = 8;
  localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  // Field widths
  localparam int SLOT_W  = 8;
  localparam int USED_W  = 9;
  localparam int PAGE_W  = 17;
  localparam int COUNT_W = 31;
  localparam int THR_W   = 23;

  localparam logic [PAGE_W-1:0]  PAGE_DEFAULT = 17'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADD_OLD   = 3'd0,
    ST_ADD_NEW   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_BAD_INDEX = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_READ
  } state_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [63:0]        key_low;
    logic [55:0]        key_high;
    logic [63:0]        rss;
    logic [63:0]        user;
    logic [63:0]        system;
    logic [COUNT_W-1:0] process;
    logic [COUNT_W-1:0] thread;
  } entry_t;

  // Zero every name byte after the first zero byte; returns {high, low}
  function automatic logic [119:0] canon_name(input logic [63:0] lo,
                                              input logic [55:0] hi);
    logic [119:0] n;
    logic         ended;
    n     = {hi, lo};
    ended = 1'b0;
    for (int b = 0; b < 15; b++) begin
      if (ended) begin
        n[b*8 +: 8] = 8'h00;
      end else if (n[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/keyed_group_sum_table.sv */
// Add: S_SCAN compares one entry per cycle, set by the single read port of the
//   table memory feeding the key compare; then S_ADD writes on a hit or a new
//   name, a full table strobes from S_SCAN. Read: result loaded in S_READ; clear,
//   empty name and bad index: done in the cycle after accept. busy is high until
//   the strobe cycle, in which the next word may already start.
// Reset (rst, synchronous) empties the table and sets page size to 4096.
`include "keyed_group_sum_table_assert.svh"
// ----------------------------------------------------------------------------
// keyed_group_sum_table
// Group-by accumulator keyed on a process name of up to 15 bytes.
// ----------------------------------------------------------------------------
module keyed_group_sum_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [63:0]                   name_low,
  input  logic [55:0]                   name_high,
  input  logic [31:0]                   rss_pages,
  input  logic [63:0]                   user_ticks,
  input  logic [63:0]                   system_ticks,
  input  logic [kgst_pkg::THR_W-1:0]    thread_count,
  input  logic [kgst_pkg::IN_IDX_W-1:0] entry_index,
  input  logic                          cfg_wr_en,
  input  logic [kgst_pkg::PAGE_W-1:0]   cfg_wr_data,
  output logic                          done,
  output logic [2:0]                    status,
  output logic [kgst_pkg::SLOT_W-1:0]   slot,
  output logic [63:0]                   key_low,
  output logic [55:0]                   key_high,
  output logic [63:0]                   rss_total,
  output logic [63:0]                   user_total,
  output logic [63:0]                   system_total,
  output logic [kgst_pkg::COUNT_W-1:0]  process_total,
  output logic [kgst_pkg::COUNT_W-1:0]  thread_total,
  output logic [kgst_pkg::USED_W-1:0]   entries_used
);
  import kgst_pkg::*;

  logic [PAGE_W-1:0] page_bytes;
  logic [PAGE_W-1:0] page_eff;
  logic              ram_re;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_rdata;
  entry_t            acc_upd;
  entry_t            acc_base;
  logic              acc_load;
  status_t           res_status;
  entry_t            res_entry;

  // Page size register; zero counts as the default
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_DEFAULT;
    end else if (cfg_wr_en) begin
      page_bytes <= cfg_wr_data;
    end
  end

  assign page_eff = (page_bytes == '0) ? PAGE_DEFAULT : page_bytes;

  // Entry memory
  kgst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (acc_upd),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accumulate unit
  kgst_acc u_acc (
    .clk            (clk),
    .load           (acc_load),
    .rss_pages      (rss_pages),
    .page_bytes     (page_eff),
    .user_ticks     (user_ticks),
    .system_ticks   (system_ticks),
    .thread_count   (thread_count),
    .base           (acc_base),
    .upd            (acc_upd)
  );

  // Sequencer
  kgst_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .name_low    (name_low),
    .name_high   (name_high),
    .entry_index (entry_index),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .acc_load    (acc_load),
    .acc_base    (acc_base),
    .acc_upd     (acc_upd),
    .done        (done),
    .res_status  (res_status),
    .res_slot    (slot),
    .res_entry   (res_entry),
    .res_used    (entries_used)
  );

  // Split the result word onto the ports
  assign status        = res_status;
  assign key_low       = res_entry.key_low;
  assign key_high      = res_entry.key_high;
  assign rss_total     = res_entry.rss;
  assign user_total    = res_entry.user;
  assign system_total  = res_entry.system;
  assign process_total = res_entry.process;
  assign thread_total  = res_entry.thread;

  // Checks
  `KGST_ASSERT_NEXT(a_add_goes_busy, start && !busy && (mode == MODE_ADD) && (name_low[7:0] != 8'h00), busy, "add word with a name did not start a scan")
  `KGST_ASSERT_SAME(a_new_entry_one_proc, done && (status == ST_ADD_NEW), process_total == 31'd1, "fresh entry does not count exactly one process")
  `KGST_ASSERT_SAME(a_clear_empties, done && (status == ST_CLEARED), entries_used == '0, "clear left entries in use")
  `KGST_ASSERT_SAME(a_reject_zeroed, done && ((status == ST_FULL) || (status == ST_EMPTY) || (status == ST_BAD_INDEX)), (slot == '0) && (rss_total == '0) && (process_total == '0), "rejected word carries entry data")

endmodule

/* rtl/kgst_ram.sv */
// ----------------------------------------------------------------------------
// kgst_ram
// Generic single-write, single-read RAM with registered, enabled read data.
// ----------------------------------------------------------------------------
module kgst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold the last word while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/kgst_acc.sv */
// ----------------------------------------------------------------------------
// kgst_acc
// Sample holder and accumulate unit: resident bytes product, 64-bit wrapping
// sums and saturating counts applied to one entry.
// ----------------------------------------------------------------------------
module kgst_acc (
  input  logic                          clk,
  input  logic                          load,
  input  logic [31:0]                   rss_pages,
  input  logic [kgst_pkg::PAGE_W-1:0]   page_bytes,
  input  logic [63:0]                   user_ticks,
  input  logic [63:0]                   system_ticks,
  input  logic [kgst_pkg::THR_W-1:0]    thread_count,
  input  kgst_pkg::entry_t              base,
  output kgst_pkg::entry_t              upd
);
  import kgst_pkg::*;

  logic [31:0]            res_q;
  logic [PAGE_W-1:0]      ps_q;
  logic [63:0]            user_q;
  logic [63:0]            sys_q;
  logic [THR_W-1:0]       thr_q;
  logic [31+PAGE_W:0]     prod;
  logic [COUNT_W:0]       thr_sum;

  // Hold the sample of the accepted word
  always_ff @(posedge clk) begin
    if (load) begin
      res_q  <= rss_pages;
      ps_q   <= page_bytes;
      user_q <= user_ticks;
      sys_q  <= system_ticks;
      thr_q  <= thread_count;
    end
  end

  // Register the resident bytes product
  always_ff @(posedge clk) begin
    prod <= res_q * ps_q;
  end

  // Apply the sample to the entry
  always_comb begin
    thr_sum      = {1'b0, base.thread} + (COUNT_W+1)'(thr_q);
    upd          = base;
    upd.rss      = base.rss + 64'(prod);
    upd.user     = base.user + user_q;
    upd.system   = base.system + sys_q;
    upd.process  = (base.process == COUNT_MAX) ? COUNT_MAX : base.process + 1'b1;
    upd.thread   = thr_sum[COUNT_W] ? COUNT_MAX : thr_sum[COUNT_W-1:0];
  end

endmodule

/* rtl/kgst_seq.sv */
// ----------------------------------------------------------------------------
// kgst_seq
// Sequencer: accepts a word, scans the table one entry a cycle through the
// shared key comparator, drives the memory and registers the result word.
// ----------------------------------------------------------------------------
module kgst_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [63:0]                   name_low,
  input  logic [55:0]                   name_high,
  input  logic [kgst_pkg::IN_IDX_W-1:0] entry_index,
  // memory side
  output logic                          ram_re,
  output logic [kgst_pkg::IDX_W-1:0]    ram_raddr,
  input  kgst_pkg::entry_t              ram_rdata,
  output logic                          ram_we,
  output logic [kgst_pkg::IDX_W-1:0]    ram_waddr,
  // accumulate unit side
  output logic                          acc_load,
  output kgst_pkg::entry_t              acc_base,
  input  kgst_pkg::entry_t              acc_upd,
  // result word
  output logic                          done,
  output kgst_pkg::status_t             res_status,
  output logic [kgst_pkg::SLOT_W-1:0]   res_slot,
  output kgst_pkg::entry_t              res_entry,
  output logic [kgst_pkg::USED_W-1:0]   res_used
);
  import kgst_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   occupied, occupied_next;
  logic [CNT_W-1:0]   scan_idx, scan_idx_next;
  logic               cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]   cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]   slot_q, slot_next;
  logic               is_new, is_new_next;
  logic [63:0]        key_lo, key_lo_next;
  logic [55:0]        key_hi, key_hi_next;
  logic [119:0]       name_c;
  logic [CMP_W-1:0]   idx_ext;
  logic [CMP_W-1:0]   occ_ext;
  logic               key_eq;
  logic               res_ld;
  status_t            status_val;
  logic [IDX_W-1:0]   slot_val;
  entry_t             entry_val;
  entry_t             fresh;

  assign name_c  = canon_name(name_low, name_high);
  assign idx_ext = CMP_W'(entry_index);
  assign occ_ext = CMP_W'(occupied);
  assign key_eq  = (ram_rdata.key_low == key_lo) && (ram_rdata.key_high == key_hi);
  assign busy    = (state != S_IDLE);

  // Zeroed totals under the held name
  always_comb begin
    fresh          = '0;
    fresh.key_low  = key_lo;
    fresh.key_high = key_hi;
  end

  assign acc_base  = is_new ? fresh : ram_rdata;
  assign ram_waddr = slot_q;

  // Next state and memory control
  always_comb begin
    state_next    = state;
    occupied_next = occupied;
    scan_idx_next = scan_idx;
    cmp_vld_next  = 1'b0;
    cmp_idx_next  = cmp_idx;
    slot_next     = slot_q;
    is_new_next   = is_new;
    key_lo_next   = key_lo;
    key_hi_next   = key_hi;
    ram_re        = 1'b0;
    ram_raddr     = IDX_W'(scan_idx);
    ram_we        = 1'b0;
    acc_load      = 1'b0;
    res_ld        = 1'b0;
    status_val    = ST_BAD_INDEX;
    slot_val      = '0;
    entry_val     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          acc_load      = 1'b1;
          key_lo_next   = name_c[63:0];
          key_hi_next   = name_c[119:64];
          scan_idx_next = '0;
          case (mode)
            MODE_ADD: begin
              if (name_c[7:0] == 8'h00) begin
                res_ld     = 1'b1;
                status_val = ST_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_READ: begin
              if (idx_ext < occ_ext) begin
                ram_re     = 1'b1;
                ram_raddr  = IDX_W'(idx_ext);
                slot_next  = IDX_W'(idx_ext);
                state_next = S_READ;
              end else begin
                res_ld     = 1'b1;
                status_val = ST_BAD_INDEX;
              end
            end
            MODE_CLEAR: begin
              occupied_next = '0;
              res_ld        = 1'b1;
              status_val    = ST_CLEARED;
            end
            default: begin
              res_ld     = 1'b1;
              status_val = ST_BAD_INDEX;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Compare the entry read last cycle, issue the next read
        if (cmp_vld && key_eq) begin
          slot_next   = cmp_idx;
          is_new_next = 1'b0;
          state_next  = S_ADD;
        end else if (scan_idx < occupied) begin
          ram_re        = 1'b1;
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = IDX_W'(scan_idx);
          scan_idx_next = scan_idx + 1'b1;
        end else if (occupied == CNT_W'(ENTRIES)) begin
          res_ld     = 1'b1;
          status_val = ST_FULL;
          state_next = S_IDLE;
        end else begin
          is_new_next = 1'b1;
          slot_next   = IDX_W'(occupied);
          state_next  = S_ADD;
        end
      end
      S_ADD: begin
        ram_we     = 1'b1;
        res_ld     = 1'b1;
        status_val = is_new ? ST_ADD_NEW : ST_ADD_OLD;
        slot_val   = slot_q;
        entry_val  = acc_upd;
        if (is_new) begin
          occupied_next = occupied + 1'b1;
        end
        state_next = S_IDLE;
      end
      S_READ: begin
        res_ld     = 1'b1;
        status_val = ST_READ_OK;
        slot_val   = slot_q;
        entry_val  = ram_rdata;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occupied <= '0;
      cmp_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      occupied <= occupied_next;
      cmp_vld  <= cmp_vld_next;
      done     <= res_ld;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    slot_q   <= slot_next;
    is_new   <= is_new_next;
    key_lo   <= key_lo_next;
    key_hi   <= key_hi_next;
    if (res_ld) begin
      res_status <= status_val;
      res_slot   <= SLOT_W'(slot_val);
      res_entry  <= entry_val;
      res_used   <= USED_W'(occupied_next);
    end
  end

endmodule

/* tb/sv/tb_keyed_group_sum_table.sv */
// ----------------------------------------------------------------------------
// tb_keyed_group_sum_table
// Self-checking bench for the group-by sum table. A scoreboard class keeps
// its own copy of the table and the page size. It predicts one result row
// for every word the block takes, and it compares each strobed row field by
// field. Directed words cover the edge cases. Random phases then mix pool
// names, fresh names, reads, clears and noise, fill the table past full and
// drive the thread count into saturation, under several page sizes and
// sender gap rates.
// ----------------------------------------------------------------------------
module tb_keyed_group_sum_table;
  timeunit 1ns;
  timeprecision 1ps;

  import kgst_pkg::*;

  localparam int PERIOD      = 10;
  localparam int POOL_SIZE   = 48;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef enum {PH_MIXED, PH_FILL, PH_SATURATE} phase_kind_t;

  // One command word as the block takes it
  typedef struct {
    mode_t             mode;
    logic [63:0]       name_low;
    logic [55:0]       name_high;
    logic [31:0]       pages;
    logic [63:0]       user;
    logic [63:0]       system;
    logic [THR_W-1:0]  threads;
    logic [7:0]        index;
  } sample_word_t;

  // One result row as the block strobes it
  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        key_low;
    logic [55:0]        key_high;
    logic [63:0]        rss;
    logic [63:0]        user;
    logic [63:0]        system;
    logic [COUNT_W-1:0] procs;
    logic [COUNT_W-1:0] threads;
    logic [USED_W-1:0]  used;
  } group_row_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the table, rows still to arrive
  // --------------------------------------------------------------------------
  class group_sum_scoreboard;
    logic [63:0]        key_low_mem  [ENTRIES];
    logic [55:0]        key_high_mem [ENTRIES];
    logic [63:0]        rss_mem      [ENTRIES];
    logic [63:0]        user_mem     [ENTRIES];
    logic [63:0]        system_mem   [ENTRIES];
    logic [COUNT_W-1:0] procs_mem    [ENTRIES];
    logic [COUNT_W-1:0] threads_mem  [ENTRIES];
    int unsigned        used_entries;
    logic [PAGE_W-1:0]  page_bytes;
    group_row_t         awaited_rows [$];
    int                 mismatch_count;
    int                 words_noted;
    int                 status_seen [8];

    function new();
      used_entries   = 0;
      page_bytes     = PAGE_DEFAULT;
      mismatch_count = 0;
      words_noted    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_page_bytes(logic [PAGE_W-1:0] value);
      page_bytes = value;
    endfunction

    // Zero every name byte past the first zero byte
    function logic [119:0] trim_name(logic [119:0] raw);
      logic [119:0] t;
      bit           ended;
      t     = raw;
      ended = 1'b0;
      for (int b = 0; b < 15; b++) begin
        if (ended) begin
          t[b*8 +: 8] = 8'h00;
        end else if (t[b*8 +: 8] == 8'h00) begin
          ended = 1'b1;
        end
      end
      return t;
    endfunction

    // Add and clamp at the largest count
    function logic [COUNT_W-1:0] add_capped(logic [COUNT_W-1:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > {2'b00, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function group_row_t blank_row(status_t st);
      group_row_t r;
      r.status   = st;
      r.slot     = '0;
      r.key_low  = '0;
      r.key_high = '0;
      r.rss      = '0;
      r.user     = '0;
      r.system   = '0;
      r.procs    = '0;
      r.threads  = '0;
      r.used     = '0;
      return r;
    endfunction

    function group_row_t entry_row(status_t st, int unsigned i);
      group_row_t r;
      r          = blank_row(st);
      r.slot     = i[SLOT_W-1:0];
      r.key_low  = key_low_mem[i];
      r.key_high = key_high_mem[i];
      r.rss      = rss_mem[i];
      r.user     = user_mem[i];
      r.system   = system_mem[i];
      r.procs    = procs_mem[i];
      r.threads  = threads_mem[i];
      return r;
    endfunction

    // Apply one word to the private table and form the row it yields
    function group_row_t fold_word(sample_word_t w);
      group_row_t   r;
      logic [119:0] name;
      logic [63:0]  bytes_per_page;
      int unsigned  hit;
      bit           fresh;
      r = blank_row(ST_BAD_INDEX);
      case (w.mode)
        MODE_ADD: begin
          name = trim_name({w.name_high, w.name_low});
          if (name[7:0] == 8'h00) begin
            r = blank_row(ST_EMPTY);
          end else begin
            hit = ENTRIES;
            for (int i = 0; i < used_entries; i++) begin
              if (hit == ENTRIES && key_low_mem[i] == name[63:0] &&
                  key_high_mem[i] == name[119:64]) hit = i;
            end
            if (hit == ENTRIES && used_entries >= ENTRIES) begin
              r = blank_row(ST_FULL);
            end else begin
              bytes_per_page = (page_bytes == '0) ? 64'(PAGE_DEFAULT) : 64'(page_bytes);
              fresh          = (hit == ENTRIES);
              // Take the next free entry with zeroed totals
              if (fresh) begin
                hit               = used_entries;
                used_entries++;
                key_low_mem[hit]  = name[63:0];
                key_high_mem[hit] = name[119:64];
                rss_mem[hit]      = '0;
                user_mem[hit]     = '0;
                system_mem[hit]   = '0;
                procs_mem[hit]    = '0;
                threads_mem[hit]  = '0;
              end
              rss_mem[hit]     += 64'(w.pages) * bytes_per_page;
              user_mem[hit]    += w.user;
              system_mem[hit]  += w.system;
              procs_mem[hit]    = add_capped(procs_mem[hit], 32'd1);
              threads_mem[hit]  = add_capped(threads_mem[hit], 32'(w.threads));
              r = entry_row(fresh ? ST_ADD_NEW : ST_ADD_OLD, hit);
            end
          end
        end
        MODE_READ: begin
          if (w.index < used_entries) r = entry_row(ST_READ_OK, w.index);
          else r = blank_row(ST_BAD_INDEX);
        end
        MODE_CLEAR: begin
          used_entries = 0;
          r = blank_row(ST_CLEARED);
        end
        default: r = blank_row(ST_BAD_INDEX);
      endcase
      r.used = used_entries[USED_W-1:0];
      return r;
    endfunction

    function void note_word(sample_word_t w);
      awaited_rows.push_back(fold_word(w));
      words_noted++;
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_row(group_row_t got);
      group_row_t want;
      if (awaited_rows.size() == 0) begin
        mismatch_count++;
        $display("%0t: stray row, expected none, actual status %0d", $time, got.status);
        return;
      end
      want = awaited_rows.pop_front();
      status_seen[want.status]++;
      compare_field("status",        64'(want.status),   64'(got.status));
      compare_field("slot",          64'(want.slot),     64'(got.slot));
      compare_field("key_low",       want.key_low,       got.key_low);
      compare_field("key_high",      64'(want.key_high), 64'(got.key_high));
      compare_field("rss_total",     want.rss,           got.rss);
      compare_field("user_total",    want.user,          got.user);
      compare_field("system_total",  want.system,        got.system);
      compare_field("process_total", 64'(want.procs),    64'(got.procs));
      compare_field("thread_total",  64'(want.threads),  64'(got.threads));
      compare_field("entries_used",  64'(want.used),     64'(got.used));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block ports
  // --------------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic                busy;
  logic [1:0]          mode           = '0;
  logic [63:0]         name_low       = '0;
  logic [55:0]         name_high      = '0;
  logic [31:0]         rss_pages      = '0;
  logic [63:0]         user_ticks     = '0;
  logic [63:0]         system_ticks   = '0;
  logic [THR_W-1:0]    thread_count   = '0;
  logic [IN_IDX_W-1:0] entry_index    = '0;
  logic                cfg_wr_en      = 1'b0;
  logic [PAGE_W-1:0]   cfg_wr_data    = '0;
  logic                done;
  logic [2:0]          status;
  logic [SLOT_W-1:0]   slot;
  logic [63:0]         key_low;
  logic [55:0]         key_high;
  logic [63:0]         rss_total;
  logic [63:0]         user_total;
  logic [63:0]         system_total;
  logic [COUNT_W-1:0]  process_total;
  logic [COUNT_W-1:0]  thread_total;
  logic [USED_W-1:0]   entries_used;

  group_sum_scoreboard group_sums = new();

  logic [119:0] name_pool [POOL_SIZE];
  int           pool_len  [POOL_SIZE];
  int unsigned  cycle_count = 0;

  keyed_group_sum_table dut (.*);

  always #(PERIOD / 2) clk = ~clk;

  // Note accepted words and config writes, check strobed rows
  always @(posedge clk) begin : watch_ports
    sample_word_t w;
    group_row_t   r;
    if (!rst) begin
      if (cfg_wr_en) group_sums.set_page_bytes(cfg_wr_data);
      if (start && !busy) begin
        w.mode      = mode_t'(mode);
        w.name_low  = name_low;
        w.name_high = name_high;
        w.pages     = rss_pages;
        w.user      = user_ticks;
        w.system    = system_ticks;
        w.threads   = thread_count;
        w.index     = entry_index;
        group_sums.note_word(w);
      end
      if (done) begin
        r.status   = status_t'(status);
        r.slot     = slot;
        r.key_low  = key_low;
        r.key_high = key_high;
        r.rss      = rss_total;
        r.user     = user_total;
        r.system   = system_total;
        r.procs    = process_total;
        r.threads  = thread_total;
        r.used     = entries_used;
        group_sums.check_row(r);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  // Name of len nonzero bytes; junk fills the bytes after the terminator
  function automatic logic [119:0] make_name(int len, bit junk);
    logic [119:0] n;
    n = '0;
    for (int b = 0; b < 15; b++) begin
      if (b < len) n[b*8 +: 8] = 8'($urandom_range(255, 1));
      else if (junk && b > len) n[b*8 +: 8] = 8'($urandom_range(255, 0));
    end
    return n;
  endfunction

  function automatic logic [119:0] pool_name(int k, bit junk);
    logic [119:0] n;
    n = name_pool[k];
    if (junk) begin
      for (int b = pool_len[k] + 1; b < 15; b++) n[b*8 +: 8] = 8'($urandom_range(255, 0));
    end
    return n;
  endfunction

  // Add word with random sample content, extremes now and then
  function automatic sample_word_t add_sample(logic [119:0] name);
    sample_word_t w;
    int           pick;
    pick        = $urandom_range(9);
    w.mode      = MODE_ADD;
    w.name_low  = name[63:0];
    w.name_high = name[119:64];
    w.pages     = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    w.user      = (pick == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
    w.system    = (pick == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
    case ($urandom_range(3))
      0:       w.threads = THR_W'($urandom_range(16, 0));
      1:       w.threads = '1;
      2:       w.threads = THR_W'(4194304);
      default: w.threads = THR_W'($urandom);
    endcase
    w.index = 8'($urandom);
    return w;
  endfunction

  // Read, clear or unused word; the sample fields carry noise
  function automatic sample_word_t ctl_word(mode_t m, logic [7:0] idx);
    sample_word_t w;
    w       = add_sample(make_name(15, 1'b0));
    w.mode  = m;
    w.index = idx;
    return w;
  endfunction

  function automatic sample_word_t mixed_word();
    int pick;
    int k;
    pick = $urandom_range(99);
    k    = $urandom_range(POOL_SIZE - 1);
    if (pick < 58) return add_sample(pool_name(k, $urandom_range(2) == 0));
    if (pick < 68) return add_sample(make_name($urandom_range(15, 1), 1'($urandom_range(1))));
    if (pick < 84) return ctl_word(MODE_READ, 8'($urandom_range(POOL_SIZE)));
    if (pick < 88) return ctl_word(MODE_READ, 8'($urandom));
    if (pick < 91) return ctl_word(MODE_CLEAR, 8'($urandom));
    if (pick < 96) return add_sample(make_name(0, 1'b1));
    return ctl_word(MODE_NONE, 8'($urandom));
  endfunction

  // Clear, push well past the table depth, then probe the full table
  function automatic sample_word_t fill_word(int i);
    if (i == 0) return ctl_word(MODE_CLEAR, 8'h00);
    if (i <= 290) begin
      if ($urandom_range(99) < 12)
        return add_sample(pool_name($urandom_range(POOL_SIZE - 1), 1'($urandom_range(1))));
      return add_sample(make_name(15, 1'b0));
    end
    if ($urandom_range(1)) return ctl_word(MODE_READ, 8'($urandom));
    if ($urandom_range(1))
      return add_sample(pool_name($urandom_range(POOL_SIZE - 1), 1'($urandom_range(1))));
    return add_sample(make_name($urandom_range(15, 1), 1'b1));
  endfunction

  // Hammer one name with large thread counts until the count clamps
  function automatic sample_word_t saturate_word(int i);
    sample_word_t w;
    if (i == 0) return ctl_word(MODE_CLEAR, 8'h00);
    if ($urandom_range(19) == 0) return ctl_word(MODE_READ, 8'($urandom_range(1)));
    w = add_sample(pool_name(1, 1'($urandom_range(1))));
    if ($urandom_range(19) != 0) w.threads = '1;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Hold start low for a random gap, then present the word until taken
  task automatic issue_word(sample_word_t w, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    mode           <= w.mode;
    name_low       <= w.name_low;
    name_high      <= w.name_high;
    rss_pages      <= w.pages;
    user_ticks     <= w.user;
    system_ticks   <= w.system;
    thread_count   <= w.threads;
    entry_index    <= w.index;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for every awaited row
  task automatic settle_table();
    start <= 1'b0;
    while (group_sums.awaited_rows.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_page(logic [PAGE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(phase_kind_t kind, int count, int idle_pct);
    sample_word_t w;
    for (int i = 0; i < count; i++) begin
      case (kind)
        PH_FILL:     w = fill_word(i);
        PH_SATURATE: w = saturate_word(i);
        default:     w = mixed_word();
      endcase
      issue_word(w, idle_pct);
    end
    settle_table();
  endtask

  task automatic run_directed();
    sample_word_t w;
    sample_word_t plan [$];
    logic [119:0] ff_name;
    ff_name = '1;
    // Read from the empty table
    plan.push_back(ctl_word(MODE_READ, 8'h00));
    // Empty name with junk behind the terminator
    w = add_sample('0);
    w.name_low  = 64'hFFFF_FFFF_FFFF_FF00;
    w.name_high = '1;
    plan.push_back(w);
    // One-byte name with the page, user and system fields at their top
    w = add_sample(120'h41);
    w.pages   = '1;
    w.user    = '1;
    w.system  = '1;
    w.threads = THR_W'(4194304);
    plan.push_back(w);
    // Same name behind junk: must hit entry 0 and wrap the tick sums
    w = add_sample('0);
    w.name_low  = 64'hDEAD_BEEF_CAFE_0041;
    w.name_high = '1;
    w.pages     = 32'd2;
    w.user      = 64'd5;
    w.system    = 64'd1;
    w.threads   = '1;
    plan.push_back(w);
    // Full fifteen-byte name, zero sample then all-ones threads
    w = add_sample(ff_name);
    w.pages   = '0;
    w.user    = '0;
    w.system  = '0;
    w.threads = '0;
    plan.push_back(w);
    w = add_sample(ff_name);
    w.threads = '1;
    plan.push_back(w);
    plan.push_back(add_sample({56'h01_0101_0101_0101, 64'h0101_0101_0101_0142}));
    // Reads inside and past the used range
    plan.push_back(ctl_word(MODE_READ, 8'd0));
    plan.push_back(ctl_word(MODE_READ, 8'd1));
    plan.push_back(ctl_word(MODE_READ, 8'd2));
    plan.push_back(ctl_word(MODE_READ, 8'd3));
    plan.push_back(ctl_word(MODE_READ, 8'hFF));
    plan.push_back(ctl_word(MODE_NONE, 8'h00));
    // Clear, then reuse entry 0 from zeroed totals
    plan.push_back(ctl_word(MODE_CLEAR, 8'hFF));
    plan.push_back(ctl_word(MODE_READ, 8'd0));
    plan.push_back(add_sample(120'h41));
    plan.push_back(ctl_word(MODE_READ, 8'd0));
    plan.push_back(ctl_word(MODE_CLEAR, 8'h00));
    foreach (plan[i]) issue_word(plan[i], 0);
    settle_table();
  endtask

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k]  = $urandom_range(15, 1);
      name_pool[k] = make_name(pool_len[k], 1'b0);
    end
    pool_len[0]  = 15;
    name_pool[0] = '1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    write_page('0);
    run_phase(PH_MIXED, 180, 0);
    write_page(17'd512);
    run_phase(PH_MIXED, 180, 82);
    write_page(17'd65536);
    run_phase(PH_FILL, 330, 24);
    write_page('1);
    run_phase(PH_SATURATE, 340, 0);
    write_page(PAGE_W'($urandom_range(65536, 512)));
    run_phase(PH_MIXED, 130, 82);
    write_page(PAGE_DEFAULT);
    run_phase(PH_MIXED, 130, 24);
    repeat (8) @(posedge clk);

    $display("Covered %0d words: %0d hits, %0d new entries, %0d dropped on a full table, %0d empty names",
             group_sums.words_noted, group_sums.status_seen[ST_ADD_OLD],
             group_sums.status_seen[ST_ADD_NEW], group_sums.status_seen[ST_FULL],
             group_sums.status_seen[ST_EMPTY]);
    $display("  %0d reads, %0d bad index or unused mode, %0d clears, over six page sizes",
             group_sums.status_seen[ST_READ_OK], group_sums.status_seen[ST_BAD_INDEX],
             group_sums.status_seen[ST_CLEARED]);
    if (group_sums.mismatch_count == 0 && group_sums.awaited_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* keyed_group_sum_table.f */
+incdir+rtl
rtl/kgst_pkg.sv
rtl/kgst_ram.sv
rtl/kgst_acc.sv
rtl/kgst_seq.sv
rtl/keyed_group_sum_table.sv
tb/sv/tb_keyed_group_sum_table.sv
